>>> rtl/scfd_pkg.sv
// ----------------------------------------------------------------------------
// scfd_pkg: shared types and constants for the serial CAN frame deframer
// Header codes, the one-hot parser states and the frame record that moves
// from the parser to the result register.
// ----------------------------------------------------------------------------
package scfd_pkg;

    localparam int MaxPayload = 8;
    localparam int PayloadIdxW = $clog2(MaxPayload);

    localparam logic [7:0] HdrStdData   = 8'h55;
    localparam logic [7:0] HdrStdRemote = 8'h5A;
    localparam logic [7:0] HdrExtData   = 8'hA5;
    localparam logic [7:0] HdrExtRemote = 8'hAA;

    typedef enum logic [7:0] {
        ST_HEADER  = 8'b0000_0001,
        ST_ID0     = 8'b0000_0010,
        ST_ID1     = 8'b0000_0100,
        ST_ID2     = 8'b0000_1000,
        ST_ID3     = 8'b0001_0000,
        ST_LEN     = 8'b0010_0000,
        ST_PAYLOAD = 8'b0100_0000,
        ST_CHECK   = 8'b1000_0000
    } parse_state_t;

    typedef struct packed {
        logic [31:0]                  frame_id;
        logic                         is_extended;
        logic                         is_remote;
        logic [3:0]                   data_length;
        logic [MaxPayload-1:0][7:0]   payload;
    } frame_t;

endpackage

>>> rtl/scfd_in_stage.sv
// ----------------------------------------------------------------------------
// scfd_in_stage: input byte register
// Holds one received byte until the parser consumes it; takes a new beat in
// the same cycle the held one is consumed.
// ----------------------------------------------------------------------------
module scfd_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       consume,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_ready    = !valid_reg || consume;
    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (consume) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

endmodule

>>> rtl/scfd_parser.sv
// ----------------------------------------------------------------------------
// scfd_parser: frame parser
// One-hot state machine with running checksum, identifier shifter and
// payload store; flags a finished frame when the check byte matches.
// ----------------------------------------------------------------------------
module scfd_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_valid,
    input  logic [7:0]           byte_data,
    output logic                 res_valid,
    output scfd_pkg::frame_t     res_frame
);

    scfd_pkg::parse_state_t state_reg, state_next;
    logic [7:0]  sum_reg, sum_next;
    logic [31:0] id_reg, id_next;
    logic        ext_reg, ext_next;
    logic        rem_reg, rem_next;
    logic [3:0]  len_reg, len_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [scfd_pkg::MaxPayload-1:0][7:0] pay_reg, pay_next;

    logic [7:0] sum_add;
    logic       hdr_known;

    assign sum_add   = sum_reg + byte_data;
    assign hdr_known = (byte_data == scfd_pkg::HdrStdData)   ||
                       (byte_data == scfd_pkg::HdrStdRemote) ||
                       (byte_data == scfd_pkg::HdrExtData)   ||
                       (byte_data == scfd_pkg::HdrExtRemote);

    always_comb begin
        state_next = state_reg;
        sum_next   = sum_reg;
        id_next    = id_reg;
        ext_next   = ext_reg;
        rem_next   = rem_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        pay_next   = pay_reg;
        res_valid  = 1'b0;
        if (byte_valid) begin
            unique case (state_reg)
                scfd_pkg::ST_HEADER: begin
                    sum_next = byte_data;
                    if (hdr_known) begin
                        ext_next   = (byte_data == scfd_pkg::HdrExtData) ||
                                     (byte_data == scfd_pkg::HdrExtRemote);
                        rem_next   = (byte_data == scfd_pkg::HdrStdRemote) ||
                                     (byte_data == scfd_pkg::HdrExtRemote);
                        state_next = scfd_pkg::ST_ID0;
                    end
                end
                scfd_pkg::ST_ID0: begin
                    sum_next   = sum_add;
                    id_next    = {24'd0, byte_data};
                    state_next = scfd_pkg::ST_ID1;
                end
                scfd_pkg::ST_ID1: begin
                    sum_next   = sum_add;
                    id_next    = {id_reg[23:0], byte_data};
                    state_next = ext_reg ? scfd_pkg::ST_ID2 : scfd_pkg::ST_LEN;
                end
                scfd_pkg::ST_ID2: begin
                    sum_next   = sum_add;
                    id_next    = {id_reg[23:0], byte_data};
                    state_next = scfd_pkg::ST_ID3;
                end
                scfd_pkg::ST_ID3: begin
                    sum_next   = sum_add;
                    id_next    = {id_reg[23:0], byte_data};
                    state_next = scfd_pkg::ST_LEN;
                end
                scfd_pkg::ST_LEN: begin
                    sum_next = sum_add;
                    // drop the frame on an oversize length, keep the old length
                    if (byte_data > 8'(scfd_pkg::MaxPayload)) begin
                        state_next = scfd_pkg::ST_HEADER;
                    end else begin
                        len_next   = byte_data[3:0];
                        cnt_next   = 4'd0;
                        state_next = (!rem_reg && byte_data != 8'd0) ?
                                     scfd_pkg::ST_PAYLOAD : scfd_pkg::ST_CHECK;
                    end
                end
                scfd_pkg::ST_PAYLOAD: begin
                    sum_next = sum_add;
                    pay_next[cnt_reg[scfd_pkg::PayloadIdxW-1:0]] = byte_data;
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_next >= len_reg) begin
                        state_next = scfd_pkg::ST_CHECK;
                    end
                end
                scfd_pkg::ST_CHECK: begin
                    sum_next   = ~sum_reg;
                    state_next = scfd_pkg::ST_HEADER;
                    res_valid  = (byte_data == ~sum_reg);
                end
                default: begin
                    state_next = scfd_pkg::ST_HEADER;
                end
            endcase
        end
    end

    assign res_frame.frame_id    = id_reg;
    assign res_frame.is_extended = ext_reg;
    assign res_frame.is_remote   = rem_reg;
    assign res_frame.data_length = len_reg;
    assign res_frame.payload     = pay_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= scfd_pkg::ST_HEADER;
            sum_reg   <= 8'd0;
            id_reg    <= 32'd0;
            ext_reg   <= 1'b0;
            rem_reg   <= 1'b0;
            len_reg   <= 4'd0;
            cnt_reg   <= 4'd0;
            pay_reg   <= '0;
        end else begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            id_reg    <= id_next;
            ext_reg   <= ext_next;
            rem_reg   <= rem_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            pay_reg   <= pay_next;
        end
    end

endmodule

>>> rtl/scfd_out_stage.sv
// ----------------------------------------------------------------------------
// scfd_out_stage: result register
// Holds one finished frame until the downstream side takes the beat.
// ----------------------------------------------------------------------------
module scfd_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  scfd_pkg::frame_t frame_in,
    output logic             free,
    output logic             m_valid,
    input  logic             m_ready,
    output scfd_pkg::frame_t frame_out
);

    logic             valid_reg;
    logic             valid_next;
    scfd_pkg::frame_t frame_reg;

    assign free      = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign frame_out = frame_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            frame_reg <= frame_in;
        end
    end

endmodule

>>> rtl/serial_can_frame_deframer.sv
// ----------------------------------------------------------------------------
// serial_can_frame_deframer: serial byte stream to CAN frame records
//
//   channel  | direction | beat
//   s_       | in        | one received byte (s_rx_byte)
//   m_       | out       | one checked frame (id, flags, length, 8 payload bytes)
//
// One byte per cycle sustained while m_ does not stall. A byte sits in the
// input register while the parser works on it, and a frame that passes the
// check shows on m_ in the cycle after its check byte was taken.
// A stall on m_ holds the input register; s_ready drops only while both
// registers are full. Reset is synchronous and clears parser and valids.
// ----------------------------------------------------------------------------
module serial_can_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_frame_id,
    output logic        m_is_extended,
    output logic        m_is_remote,
    output logic [3:0]  m_data_length,
    output logic [7:0]  m_payload0,
    output logic [7:0]  m_payload1,
    output logic [7:0]  m_payload2,
    output logic [7:0]  m_payload3,
    output logic [7:0]  m_payload4,
    output logic [7:0]  m_payload5,
    output logic [7:0]  m_payload6,
    output logic [7:0]  m_payload7
);

    logic             byte_valid;
    logic [7:0]       byte_data;
    logic             out_free;
    logic             consume;
    logic             res_valid;
    scfd_pkg::frame_t res_frame;
    scfd_pkg::frame_t out_frame;

    // advance the parser only when a result would have room
    assign consume = byte_valid && out_free;

    scfd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .consume    (consume),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    scfd_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (consume),
        .byte_data  (byte_data),
        .res_valid  (res_valid),
        .res_frame  (res_frame)
    );

    scfd_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (res_valid),
        .frame_in  (res_frame),
        .free      (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .frame_out (out_frame)
    );

    assign m_frame_id    = out_frame.frame_id;
    assign m_is_extended = out_frame.is_extended;
    assign m_is_remote   = out_frame.is_remote;
    assign m_data_length = out_frame.data_length;
    assign m_payload0    = out_frame.payload[0];
    assign m_payload1    = out_frame.payload[1];
    assign m_payload2    = out_frame.payload[2];
    assign m_payload3    = out_frame.payload[3];
    assign m_payload4    = out_frame.payload[4];
    assign m_payload5    = out_frame.payload[5];
    assign m_payload6    = out_frame.payload[6];
    assign m_payload7    = out_frame.payload[7];

endmodule

>>> rtl/scfd_checker.sv
// ----------------------------------------------------------------------------
// scfd_checker: port-level checks for the deframer
// Watches the result channel for reset behavior, holding and legal fields.
// ----------------------------------------------------------------------------
module scfd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_frame_id,
    input logic        m_is_extended,
    input logic [3:0]  m_data_length
);

    // no beat may appear right after reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_id) &&
                                $stable(m_data_length))
        else $error("stalled result beat changed");

    a_length_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data_length <= 4'd8)
        else $error("result length above maximum");

    // a standard frame only ever shifts in two identifier bytes
    a_std_id_width: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_extended |-> m_frame_id[31:16] == 16'd0)
        else $error("standard frame with wide identifier");

endmodule

bind serial_can_frame_deframer scfd_checker u_scfd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_frame_id    (m_frame_id),
    .m_is_extended (m_is_extended),
    .m_data_length (m_data_length)
);
